### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL.
// Sampled on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wfdc_pkg.sv
// Shared types and constants for the frame deframer.
// No dependencies.
`default_nettype none

package wfdc_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] LEN_BIAS       = 8'd3;
    localparam logic [7:0] REM_PRESS_LO   = 8'd4;
    localparam logic [7:0] REM_PRESS_HI   = 8'd2;
    localparam logic [7:0] REM_STEP       = 8'd2;
    localparam int         WORD_DEPTH_DEF = 32;

    localparam logic       KIND_WORD      = 1'b0;
    localparam logic       KIND_PRESS     = 1'b1;

    typedef struct packed {
        logic take_len;
        logic take_id;
        logic add_sum;
        logic end_frame;
        logic even_byte;
        logic odd_byte;
        logic load_word;
        logic load_press;
    } t_cmd;

    typedef struct packed {
        logic is_sync;
        logic rem_zero;
        logic sum_good;
        logic words_none;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### rtl/wfdc_ctrl.sv
// Controller: byte phase tracking and result sequencing.
// Depends on wfdc_pkg.
`default_nettype none

module wfdc_ctrl
    import wfdc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_rx_valid,
    output logic       o_rx_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_SYNC1, PH_SYNC2, PH_LEN, PH_ID, PH_EVEN, PH_ODD
    } t_phase;

    typedef enum logic [1:0] {
        MD_RUN, MD_READ, MD_LOAD, MD_PRESS
    } t_mode;

    t_phase r_phase, n_phase;
    t_mode  r_mode,  n_mode;
    logic   acc;

    assign o_rx_ready = (r_mode == MD_RUN);
    assign acc        = i_rx_valid && (r_mode == MD_RUN);

    always_comb begin
        n_phase = r_phase;
        n_mode  = r_mode;
        o_cmd   = '0;
        unique case (r_mode)
            MD_RUN: begin
                if (acc) begin
                    unique case (r_phase)
                        PH_SYNC1: n_phase = i_stat.is_sync ? PH_SYNC2 : PH_SYNC1;
                        PH_SYNC2: n_phase = i_stat.is_sync ? PH_LEN : PH_SYNC1;
                        PH_LEN: begin
                            o_cmd.take_len = 1'b1;
                            n_phase        = PH_ID;
                        end
                        PH_ID: begin
                            o_cmd.take_id = 1'b1;
                            n_phase       = PH_EVEN;
                        end
                        PH_EVEN: begin
                            o_cmd.add_sum = 1'b1;
                            if (i_stat.rem_zero) begin
                                o_cmd.end_frame = 1'b1;
                                n_phase         = PH_SYNC1;
                                if (i_stat.sum_good) begin
                                    n_mode = i_stat.words_none ? MD_PRESS : MD_READ;
                                end
                            end else begin
                                o_cmd.even_byte = 1'b1;
                                n_phase         = PH_ODD;
                            end
                        end
                        PH_ODD: begin
                            o_cmd.add_sum  = 1'b1;
                            o_cmd.odd_byte = 1'b1;
                            n_phase        = PH_EVEN;
                        end
                        default: n_phase = i_stat.is_sync ? PH_SYNC2 : PH_SYNC1;
                    endcase
                end
            end
            MD_READ: n_mode = MD_LOAD;
            MD_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_word = 1'b1;
                    n_mode          = i_stat.idx_last ? MD_PRESS : MD_READ;
                end
            end
            MD_PRESS: begin
                if (i_stat.out_free) begin
                    o_cmd.load_press = 1'b1;
                    n_mode           = MD_RUN;
                end
            end
            default: n_mode = MD_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_mode  <= MD_RUN;
        end else begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
        end
    end

endmodule

`default_nettype wire

### rtl/wfdc_dp.sv
// Datapath: length, checksum, word store, pressure and output register.
// Depends on wfdc_pkg.
`default_nettype none

module wfdc_dp
    import wfdc_pkg::*;
#(
    parameter int WORD_DEPTH = WORD_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_rx_byte,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  wire logic        i_item_ready,
    output logic             o_item_valid,
    output logic             o_item_kind,
    output logic signed [31:0] o_item_value,
    output logic [5:0]       o_item_index,
    output logic [7:0]       o_frame_number,
    output logic             o_last_item
);

    localparam int AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

    logic [7:0]  r_rem, r_sum, r_hold, r_fid;
    logic [5:0]  r_wcnt, r_total, r_idx;
    logic [31:0] r_press;
    logic [15:0] r_rd_data;
    logic [15:0] mem [WORD_DEPTH];
    logic        r_ovalid;
    logic [7:0]  rem_next;
    logic [7:0]  sum_next;
    logic        store_ok;
    logic        wr_en;

    assign rem_next = r_rem - REM_STEP;
    assign sum_next = r_sum + i_rx_byte;
    assign store_ok = (r_wcnt < 6'(WORD_DEPTH));
    assign wr_en    = i_cmd.odd_byte && (rem_next != REM_PRESS_HI)
                      && (rem_next != 8'd0) && store_ok;

    always_comb begin
        o_stat.is_sync    = (i_rx_byte == SYNC_BYTE);
        o_stat.rem_zero   = (r_rem == 8'd0);
        o_stat.sum_good   = (sum_next == 8'd0);
        o_stat.words_none = (r_wcnt == 6'd0);
        o_stat.idx_last   = ((r_idx + 6'd1) == r_total);
        o_stat.out_free   = !r_ovalid || i_item_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem    <= '0;
            r_sum    <= '0;
            r_hold   <= '0;
            r_fid    <= '0;
            r_wcnt   <= '0;
            r_total  <= '0;
            r_idx    <= '0;
            r_press  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.take_len) begin
                r_rem <= i_rx_byte - LEN_BIAS;
            end
            if (i_cmd.take_id) begin
                r_fid <= i_rx_byte;
            end
            if (i_cmd.end_frame) begin
                r_sum   <= '0;
                r_wcnt  <= '0;
                r_total <= r_wcnt;
                r_idx   <= '0;
            end else if (i_cmd.add_sum) begin
                r_sum <= sum_next;
            end
            if (i_cmd.even_byte) begin
                if (r_rem == REM_PRESS_LO) begin
                    r_press[7:0] <= i_rx_byte;
                end else if (r_rem == REM_PRESS_HI) begin
                    r_press[23:16] <= i_rx_byte;
                end else begin
                    r_hold <= i_rx_byte;
                end
            end
            if (i_cmd.odd_byte) begin
                r_rem <= rem_next;
                if (rem_next == REM_PRESS_HI) begin
                    r_press[15:8] <= i_rx_byte;
                end else if (rem_next == 8'd0) begin
                    r_press[31:24] <= i_rx_byte;
                end else if (store_ok) begin
                    r_wcnt <= r_wcnt + 6'd1;
                end
            end
            if (i_cmd.load_word) begin
                r_idx <= r_idx + 6'd1;
            end
            if (i_cmd.load_word || i_cmd.load_press) begin
                r_ovalid <= 1'b1;
            end else if (i_item_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wcnt[AW-1:0]] <= {i_rx_byte, r_hold};
        end
        r_rd_data <= mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            o_item_kind    <= KIND_WORD;
            o_item_value   <= {16'd0, r_rd_data};
            o_item_index   <= r_idx;
            o_frame_number <= r_fid;
            o_last_item    <= 1'b0;
        end else if (i_cmd.load_press) begin
            o_item_kind    <= KIND_PRESS;
            o_item_value   <= r_press;
            o_item_index   <= r_total;
            o_frame_number <= r_fid;
            o_last_item    <= 1'b1;
        end
    end

    assign o_item_valid = r_ovalid;

endmodule

`default_nettype wire

### rtl/word_frame_deframer_checksum_top.sv
// A good checksum byte starts a burst of results.
// Each stored word passes through a read state and a load state, then the pressure item, when the sink is ready.
// Byte input is held off from a good checksum byte until the pressure item is loaded.
// Throughput: one byte per cycle between bursts; output register limits a burst.
// Reset: synchronous, active low; clears phase, counters, sum and output valid.
// Depends on wfdc_pkg, wfdc_ctrl, wfdc_dp and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module word_frame_deframer_checksum_top
    import wfdc_pkg::*;
#(
    parameter int WORD_DEPTH = WORD_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rx_valid,
    output logic               o_rx_ready,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_item_valid,
    input  wire logic          i_item_ready,
    output logic               o_item_kind,
    output logic signed [31:0] o_item_value,
    output logic [5:0]         o_item_index,
    output logic [7:0]         o_frame_number,
    output logic               o_last_item
);

    localparam logic [5:0] IDX_LIM = 6'(WORD_DEPTH);

    t_cmd  cmd;
    t_stat stat;
    logic  word_out;
    logic  out_wait;

    wfdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wfdc_dp #(
        .WORD_DEPTH (WORD_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_item_ready   (i_item_ready),
        .o_item_valid   (o_item_valid),
        .o_item_kind    (o_item_kind),
        .o_item_value   (o_item_value),
        .o_item_index   (o_item_index),
        .o_frame_number (o_frame_number),
        .o_last_item    (o_last_item)
    );

    assign word_out = o_item_valid && (o_item_kind == KIND_WORD);
    assign out_wait = o_item_valid && !i_item_ready;

    `CHK_ALWAYS(a_last_is_press, !o_item_valid || (o_last_item == o_item_kind), "last flag")
    `CHK_ALWAYS(a_word_idx_range, !word_out || (o_item_index < IDX_LIM), "word index range")
    `CHK_ALWAYS(a_burst_holds_input, !word_out || !o_rx_ready, "input open mid burst")
    `CHK_ALWAYS(a_one_load, !(cmd.load_word && cmd.load_press), "double load")
    `CHK_NEXT(a_out_hold, out_wait, o_item_valid && $stable(o_item_value), "output not held")

endmodule

`default_nettype wire
